### rtl/rmh_pkg.sv
// Shared types for the running median core.
package rmh_pkg;

   typedef struct packed {
      logic push;
      logic pop;
   } chain_cmd_type;

endpackage

### rtl/rmh_cell.sv
// One storage cell of a sorted priority chain.
module rmh_cell
   import rmh_pkg::*;
#(
   parameter int WIDTH  = 16,
   parameter bit IS_MAX = 1'b1
) (
   input  logic             clock,
   input  logic             reset,
   input  chain_cmd_type    cmd,
   input  logic [WIDTH-1:0] push_value,
   input  logic [WIDTH-1:0] prev_value,
   input  logic             prev_valid,
   input  logic             prev_stay,
   input  logic [WIDTH-1:0] next_value,
   input  logic             next_valid,
   output logic [WIDTH-1:0] value,
   output logic             valid,
   output logic             stay
);

   logic [WIDTH-1:0] value_ff, value_in;
   logic             valid_ff, valid_in;
   logic             ranks_above;

   assign ranks_above = IS_MAX ? (push_value > value_ff) : (push_value < value_ff);
   assign stay        = valid_ff && !ranks_above;

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (cmd.pop) begin
         value_in = next_value;
         valid_in = next_valid;
      end else if (cmd.push && !stay) begin
         if (prev_stay) begin
            value_in = push_value;
            valid_in = 1'b1;
         end else begin
            value_in = prev_value;
            valid_in = prev_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign value = value_ff;
   assign valid = valid_ff;

endmodule

### rtl/rmh_chain.sv
// Row of cells that keeps one half of the samples sorted with its top at cell zero.
module rmh_chain
   import rmh_pkg::*;
#(
   parameter int DEPTH  = 512,
   parameter int WIDTH  = 16,
   parameter bit IS_MAX = 1'b1
) (
   input  logic             clock,
   input  logic             reset,
   input  chain_cmd_type    cmd,
   input  logic [WIDTH-1:0] push_value,
   output logic [WIDTH-1:0] top_value,
   output logic             top_valid
);

   logic [WIDTH-1:0] cell_value [DEPTH];
   logic             cell_valid [DEPTH];
   logic             cell_stay  [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WIDTH-1:0] prev_value, next_value;
      logic             prev_valid, prev_stay, next_valid;

      if (i == 0) begin : g_head
         assign prev_value = '0;
         assign prev_valid = 1'b0;
         assign prev_stay  = 1'b1;
      end else begin : g_body
         assign prev_value = cell_value[i-1];
         assign prev_valid = cell_valid[i-1];
         assign prev_stay  = cell_stay[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign next_value = '0;
         assign next_valid = 1'b0;
      end else begin : g_link
         assign next_value = cell_value[i+1];
         assign next_valid = cell_valid[i+1];
      end

      rmh_cell #(
         .WIDTH  (WIDTH),
         .IS_MAX (IS_MAX)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .push_value (push_value),
         .prev_value (prev_value),
         .prev_valid (prev_valid),
         .prev_stay  (prev_stay),
         .next_value (next_value),
         .next_valid (next_valid),
         .value      (cell_value[i]),
         .valid      (cell_valid[i]),
         .stay       (cell_stay[i])
      );
   end

   assign top_value = cell_value[0];
   assign top_valid = cell_valid[0];

endmodule

### rtl/running_median_two_heaps_core.sv
// Top level of the running median core built from two sorted cell chains.
//
// Each request carries one unsigned sample; each produces one response with the
// median of all samples so far, doubled so that half-integer medians are exact,
// and a flag in tuser that is set when the sample was refused because
// 2*HEAP_DEPTH-1 samples are already held (the median is then unchanged).
// The lower half lives in a descending chain of cells and the upper half in an
// ascending one, so both tops sit at fixed cells. A request is taken in ST_IDLE,
// goes through ST_MOVE when a sample has to move between the halves, then
// ST_INSERT (a refused request skips both), and ends in ST_SUM, which forms the
// median from the two tops and waits while the last response is not taken.
// In a chain operation all cells shift or insert at once, independent of depth.
module running_median_two_heaps_core
   import rmh_pkg::*;
#(
   parameter int HEAP_DEPTH  = 512,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // sample
   input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // median_twice
   output logic [((SAMPLE_BITS + 8) / 8) * 8 - 1:0] rsp_tdata,
   // full_res
   output logic                                     rsp_tuser
);

   localparam int MED_BITS   = SAMPLE_BITS + 1;
   localparam int OUT_BITS   = ((SAMPLE_BITS + 8) / 8) * 8;
   localparam int CNT_BITS   = $clog2(HEAP_DEPTH + 1);
   localparam int TOT_BITS   = $clog2(2 * HEAP_DEPTH);
   localparam logic [TOT_BITS-1:0] FULL_TOTAL = TOT_BITS'(2 * HEAP_DEPTH - 1);
   localparam logic [CNT_BITS-1:0] CNT_ONE    = CNT_BITS'(1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MOVE,
      ST_INSERT,
      ST_SUM
   } state_type;

   state_type              state_ff, state_in;
   logic [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic [CNT_BITS-1:0]    lower_cnt_ff, lower_cnt_in;
   logic [CNT_BITS-1:0]    upper_cnt_ff, upper_cnt_in;
   logic [MED_BITS-1:0]    median_ff, median_in;
   logic                   from_lower_ff, from_lower_in;
   logic                   push_lower_ff, push_lower_in;
   logic                   full_ff, full_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [MED_BITS-1:0]    rsp_median_ff, rsp_median_in;
   logic                   rsp_full_ff, rsp_full_in;

   chain_cmd_type          lower_cmd, upper_cmd;
   logic [SAMPLE_BITS-1:0] lower_push, upper_push;
   logic [SAMPLE_BITS-1:0] lower_top, upper_top;
   logic                   lower_top_valid, upper_top_valid;

   logic [SAMPLE_BITS-1:0] new_sample;
   logic [MED_BITS-1:0]    new_twice, ref_median, top_sum, med_calc;
   logic [TOT_BITS-1:0]    total;
   logic                   goes_lower;

   assign new_sample = req_tdata[SAMPLE_BITS-1:0];
   assign new_twice  = {new_sample, 1'b0};
   assign total      = TOT_BITS'(lower_cnt_ff) + TOT_BITS'(upper_cnt_ff);
   assign ref_median = (total == '0) ? new_twice : median_ff;
   assign goes_lower = new_twice < ref_median;
   assign top_sum    = MED_BITS'(lower_top_valid ? lower_top : '0)
                     + MED_BITS'(upper_top_valid ? upper_top : '0);

   always_comb begin
      if (lower_cnt_ff > upper_cnt_ff) begin
         med_calc = {lower_top, 1'b0};
      end else if (upper_cnt_ff > lower_cnt_ff) begin
         med_calc = {upper_top, 1'b0};
      end else begin
         med_calc = top_sum;
      end
   end

   always_comb begin
      lower_cmd  = '0;
      upper_cmd  = '0;
      lower_push = sample_ff;
      upper_push = sample_ff;
      case (state_ff)
         ST_MOVE: begin
            if (from_lower_ff) begin
               lower_cmd.pop  = 1'b1;
               upper_cmd.push = 1'b1;
               upper_push     = lower_top;
            end else begin
               upper_cmd.pop  = 1'b1;
               lower_cmd.push = 1'b1;
               lower_push     = upper_top;
            end
         end
         ST_INSERT: begin
            lower_cmd.push = push_lower_ff;
            upper_cmd.push = !push_lower_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      sample_in     = sample_ff;
      lower_cnt_in  = lower_cnt_ff;
      upper_cnt_in  = upper_cnt_ff;
      median_in     = median_ff;
      from_lower_in = from_lower_ff;
      push_lower_in = push_lower_ff;
      full_in       = full_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_median_in = rsp_median_ff;
      rsp_full_in   = rsp_full_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               sample_in = new_sample;
               full_in   = (total == FULL_TOTAL);
               if (total == FULL_TOTAL) begin
                  state_in = ST_SUM;
               end else if (lower_cnt_ff > upper_cnt_ff) begin
                  from_lower_in = 1'b1;
                  push_lower_in = goes_lower;
                  state_in      = goes_lower ? ST_MOVE : ST_INSERT;
               end else if (upper_cnt_ff > lower_cnt_ff) begin
                  from_lower_in = 1'b0;
                  push_lower_in = goes_lower;
                  state_in      = goes_lower ? ST_INSERT : ST_MOVE;
               end else begin
                  push_lower_in = goes_lower;
                  state_in      = ST_INSERT;
               end
            end
         end
         ST_MOVE: begin
            if (from_lower_ff) begin
               lower_cnt_in = lower_cnt_ff - CNT_ONE;
               upper_cnt_in = upper_cnt_ff + CNT_ONE;
            end else begin
               upper_cnt_in = upper_cnt_ff - CNT_ONE;
               lower_cnt_in = lower_cnt_ff + CNT_ONE;
            end
            state_in = ST_INSERT;
         end
         ST_INSERT: begin
            if (push_lower_ff) begin
               lower_cnt_in = lower_cnt_ff + CNT_ONE;
            end else begin
               upper_cnt_in = upper_cnt_ff + CNT_ONE;
            end
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (!rsp_valid_ff || rsp_tready) begin
               median_in     = med_calc;
               rsp_valid_in  = 1'b1;
               rsp_median_in = med_calc;
               rsp_full_in   = full_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      sample_ff     <= sample_in;
      from_lower_ff <= from_lower_in;
      push_lower_ff <= push_lower_in;
      full_ff       <= full_in;
      rsp_median_ff <= rsp_median_in;
      rsp_full_ff   <= rsp_full_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         lower_cnt_ff <= '0;
         upper_cnt_ff <= '0;
         median_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lower_cnt_ff <= lower_cnt_in;
         upper_cnt_ff <= upper_cnt_in;
         median_ff    <= median_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   rmh_chain #(
      .DEPTH  (HEAP_DEPTH),
      .WIDTH  (SAMPLE_BITS),
      .IS_MAX (1'b1)
   ) u_lower (
      .clock      (clock),
      .reset      (reset),
      .cmd        (lower_cmd),
      .push_value (lower_push),
      .top_value  (lower_top),
      .top_valid  (lower_top_valid)
   );

   rmh_chain #(
      .DEPTH  (HEAP_DEPTH),
      .WIDTH  (SAMPLE_BITS),
      .IS_MAX (1'b0)
   ) u_upper (
      .clock      (clock),
      .reset      (reset),
      .cmd        (upper_cmd),
      .push_value (upper_push),
      .top_value  (upper_top),
      .top_valid  (upper_top_valid)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_BITS'(rsp_median_ff);
   assign rsp_tuser  = rsp_full_ff;

endmodule

### tb/running_median_two_heaps_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the running median core, with its own two-half median predictor.
module running_median_two_heaps_core_tb;

   localparam int HEAP_DEPTH  = 512;
   localparam int SAMPLE_BITS = 16;
   localparam int STORE_LIMIT = 2 * HEAP_DEPTH - 1;
   localparam int REQ_W       = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_W       = ((SAMPLE_BITS + 8) / 8) * 8;

   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef logic [SAMPLE_BITS:0]   median_type;
   typedef struct packed {
      median_type median_twice;
      logic       full_res;
   } median_rsp_type;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tuser;

   // Both halves are kept in ascending order: the lower top is the last
   // entry, the upper top the first.
   sample_type     lower_half[$];
   sample_type     upper_half[$];
   median_type     median_x2;
   median_rsp_type pending_medians[$];
   int             mismatches;
   int             checked;
   int             accepted;
   int             refused;
   bit             stalls_on;

   running_median_two_heaps_core #(
      .HEAP_DEPTH (HEAP_DEPTH),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void add_to_half(bit to_lower, sample_type v);
      int pos;
      pos = 0;
      if (to_lower) begin
         while (pos < lower_half.size() && lower_half[pos] < v) pos++;
         lower_half.insert(pos, v);
      end else begin
         while (pos < upper_half.size() && upper_half[pos] < v) pos++;
         upper_half.insert(pos, v);
      end
   endfunction

   function automatic median_rsp_type predict_median(sample_type v);
      median_rsp_type r;
      median_type     v2;
      int             nl;
      int             nu;
      v2         = {v, 1'b0};
      nl         = lower_half.size();
      nu         = upper_half.size();
      r.full_res = 1'b0;
      if (nl + nu >= STORE_LIMIT) begin
         r.full_res     = 1'b1;
         r.median_twice = median_x2;
         return r;
      end
      if (nl + nu == 0) median_x2 = v2;
      if (nl > nu) begin
         if (v2 < median_x2) begin
            add_to_half(1'b0, lower_half[$]);
            void'(lower_half.pop_back());
            add_to_half(1'b1, v);
         end else begin
            add_to_half(1'b0, v);
         end
         median_x2 = median_type'(lower_half[$]) + median_type'(upper_half[0]);
      end else if (nl == nu) begin
         if (v2 < median_x2) begin
            add_to_half(1'b1, v);
            median_x2 = {lower_half[$], 1'b0};
         end else begin
            add_to_half(1'b0, v);
            median_x2 = {upper_half[0], 1'b0};
         end
      end else begin
         if (v2 < median_x2) begin
            add_to_half(1'b1, v);
         end else begin
            add_to_half(1'b1, upper_half[0]);
            void'(upper_half.pop_front());
            add_to_half(1'b0, v);
         end
         median_x2 = median_type'(lower_half[$]) + median_type'(upper_half[0]);
      end
      r.median_twice = median_x2;
      return r;
   endfunction

   function automatic sample_type median_sample();
      return sample_type'(median_x2 >> 1);
   endfunction

   // Entered and left at a falling edge.
   task automatic send_sample(sample_type v);
      while (stalls_on && $urandom_range(99) < 10) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'(v);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_medians.insert(pending_medians.size(), predict_median(v));
      accepted++;
      if (pending_medians[$].full_res) refused++;
      @(negedge clock);
   endtask

   task automatic wait_for_responses();
      req_tvalid <= 1'b0;
      while (pending_medians.size() != 0) @(negedge clock);
   endtask

   task automatic test_first_sample_and_extremes();
      send_sample(16'hFFFF);
      send_sample(16'hFFFF);
      repeat (5) send_sample(16'h0000);
      send_sample(median_sample());
      send_sample(16'h0001);
      send_sample(16'hFFFE);
   endtask

   task automatic test_ties_and_midrange();
      send_sample(16'h8000);
      send_sample(16'h7FFF);
      send_sample(16'd12345);
      send_sample(median_sample());
      send_sample(median_sample());
      send_sample(16'd7);
      send_sample(16'd7);
      send_sample(median_sample());
   endtask

   task automatic test_random_stream(int count);
      sample_type v;
      int         kind;
      for (int n = 0; n < count; n++) begin
         stalls_on = !(n >= count / 3 && n < count / 3 + 150);
         kind = $urandom_range(99);
         if (kind < 30) v = sample_type'($urandom_range(16'hFFFF));
         else if (kind < 55) v = sample_type'($urandom_range(15));
         else if (kind < 70) v = median_sample();
         else if (kind < 85) v = median_sample() + sample_type'($urandom_range(6)) - 16'd3;
         else if (kind < 92) v = 16'hFFFF - sample_type'($urandom_range(3));
         else v = sample_type'($urandom_range(3));
         send_sample(v);
         if (n % 300 == 299) wait_for_responses();
      end
      stalls_on = 1'b1;
   endtask

   task automatic test_store_full();
      wait_for_responses();
      @(negedge clock);
      while (lower_half.size() + upper_half.size() < STORE_LIMIT) begin
         if ($urandom_range(1)) send_sample(16'hFFFF);
         else send_sample(sample_type'($urandom_range(16'hFFFF)));
      end
      send_sample(16'h0000);
      send_sample(16'hFFFF);
      send_sample(median_sample());
      repeat (17) send_sample(sample_type'($urandom_range(16'hFFFF)));
   endtask

   always @(negedge clock) begin
      rsp_tready <= !(stalls_on && $urandom_range(99) < 10);
   end

   always @(posedge clock) begin : check_responses
      median_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_medians.size() == 0) begin
            $error("response with no request pending: median_twice %0d full_res %0d",
                   rsp_tdata[SAMPLE_BITS:0], rsp_tuser);
            mismatches++;
         end else begin
            want = pending_medians.pop_front();
            checked++;
            if (rsp_tdata[SAMPLE_BITS:0] !== want.median_twice) begin
               $error("median_twice: expected %0d, got %0d",
                      want.median_twice, rsp_tdata[SAMPLE_BITS:0]);
               mismatches++;
            end
            if (rsp_tuser !== want.full_res) begin
               $error("full_res: expected %0d, got %0d", want.full_res, rsp_tuser);
               mismatches++;
            end
         end
      end
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      stalls_on  = 1'b1;
      median_x2  = '0;
      mismatches = 0;
      checked    = 0;
      accepted   = 0;
      refused    = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_first_sample_and_extremes();
      test_ties_and_midrange();
      test_random_stream(930);
      test_store_full();
      wait_for_responses();
      repeat (20) @(posedge clock);
      $display("Checked %0d medians from %0d requests; %0d were refused with the store full.",
               checked, accepted, refused);
      $display("Samples covered both extremes, ties with the median, and runs with and without stalls.");
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

### sim.f
rtl/rmh_pkg.sv
rtl/rmh_cell.sv
rtl/rmh_chain.sv
rtl/running_median_two_heaps_core.sv
tb/running_median_two_heaps_core_tb.sv
